// ===== design/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Shared widths, stream packing and the scan control group for the
// non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

  // input beat fields
  localparam int unsigned IN_TIME_W = 16;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned S_TDATA_W = 40;

  // result beat fields
  localparam int unsigned ID_W      = 5;
  localparam int unsigned RES_W     = 21;
  localparam int unsigned SUM_W     = 25;
  localparam int unsigned M_TDATA_W = 104;

  // bit positions inside tdata
  localparam int unsigned S_ARR_LSB   = 0;
  localparam int unsigned S_BURST_LSB = 16;
  localparam int unsigned S_PRIO_LSB  = 32;

  // scan sequencer to compare unit
  typedef struct packed {
    logic clear;   // start of a pass, drop both candidates
    logic sample;  // read data of this cycle is a valid entry
  } scan_ctrl_t;

endpackage

// ===== design/nps_job_mem.sv =====
// ----------------------------------------------------------------------------
// nps_job_mem
// Job store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nps_job_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 40,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // load and scan phases never overlap, so no write-to-read bypass
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nps_select.sv =====
// ----------------------------------------------------------------------------
// nps_select
// Compare unit for one scan pass: keeps the best arrived job and the
// earliest-arriving pending job as entries stream out of the job store.
// ----------------------------------------------------------------------------
module nps_select #(
  parameter int unsigned TIME_WIDTH = 16,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned CT_W       = 21,
  parameter int unsigned WORD_W     = 40
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nps_pkg::scan_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]    rd_idx_i,
  input  logic [WORD_W-1:0]   rd_word_i,
  input  logic                rd_done_i,
  input  logic [CT_W-1:0]     cur_time_i,
  output logic                pick_arrived_o,
  output logic [IDX_W-1:0]    pick_idx_o,
  output logic [TIME_WIDTH-1:0] pick_arr_o,
  output logic [TIME_WIDTH-1:0] pick_burst_o
);
  import nps_pkg::*;

  logic [TIME_WIDTH-1:0] arr, burst;
  logic [PRIO_W-1:0]     prio;
  logic                  arrived, take_best, take_min;

  logic                  best_vld_q, min_vld_q;
  logic [IDX_W-1:0]      best_idx_q, min_idx_q;
  logic [TIME_WIDTH-1:0] best_arr_q, min_arr_q, best_burst_q, min_burst_q;
  logic [PRIO_W-1:0]     best_prio_q, min_prio_q;

  assign arr   = rd_word_i[TIME_WIDTH-1:0];
  assign burst = rd_word_i[2*TIME_WIDTH-1:TIME_WIDTH];
  assign prio  = rd_word_i[2*TIME_WIDTH+PRIO_W-1:2*TIME_WIDTH];

  assign arrived = (CT_W'(arr) <= cur_time_i);

  // ascending scan: strict compares leave ties with the lower id
  assign take_best = ctrl_i.sample && !rd_done_i && arrived &&
                     (!best_vld_q || (prio < best_prio_q) ||
                      ((prio == best_prio_q) && (arr < best_arr_q)));
  assign take_min  = ctrl_i.sample && !rd_done_i &&
                     (!min_vld_q || (arr < min_arr_q) ||
                      ((arr == min_arr_q) && (prio < min_prio_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
      min_vld_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      best_vld_q <= 1'b0;
      min_vld_q  <= 1'b0;
    end else begin
      if (take_best) best_vld_q <= 1'b1;
      if (take_min)  min_vld_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_idx_q   <= rd_idx_i;
      best_arr_q   <= arr;
      best_burst_q <= burst;
      best_prio_q  <= prio;
    end
    if (take_min) begin
      min_idx_q   <= rd_idx_i;
      min_arr_q   <= arr;
      min_burst_q <= burst;
      min_prio_q  <= prio;
    end
  end

  // nothing arrived yet: idle gap, earliest pending job goes next
  assign pick_arrived_o = best_vld_q;
  assign pick_idx_o     = best_vld_q ? best_idx_q   : min_idx_q;
  assign pick_arr_o     = best_vld_q ? best_arr_q   : min_arr_q;
  assign pick_burst_o   = best_vld_q ? best_burst_q : min_burst_q;

endmodule

// ===== design/nonpreemptive_priority_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_unit
// Loads a set of jobs into a job store, then emits a non-preemptive
// priority schedule: job id, turnaround, waiting and running totals.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  s_axis    in   tdata: arrival[15:0] burst[31:16] priority[39:32];
//                 tlast: last job of the set
//  m_axis    out  tdata: job_id[4:0] turnaround[25:5] waiting[46:26]
//                 total_turnaround[71:47] total_waiting[96:72], zero pad;
//                 tuser: jobs dropped; tlast: final result of the set
//
//  Loading takes one job beat per cycle. A beat with tlast closes the set;
//  the input then stalls until the last result sits in the result register.
//  Each result costs one scan of the job store (one entry read per cycle,
//  n stored jobs) plus pick, arithmetic and hand-over.
//  The result register frees the scan while a beat waits on m_axis_tready.
//  Reset clears the set; job store contents need no clearing.
//
module nonpreemptive_priority_scheduler_unit #(
  parameter int unsigned MAX_JOBS   = 16,
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // arrival_time, burst_time, priority_req
  input  logic [nps_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,   // last_job
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // job_id, turnaround, waiting, total_turnaround, total_waiting, pad
  output logic [nps_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                          m_axis_tuser_o,   // overflow
  output logic                          m_axis_tlast_o    // last_result
);
  import nps_pkg::*;

  localparam int unsigned IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int unsigned CT_W   = TIME_WIDTH + CNT_W;
  localparam int unsigned WORD_W = 2 * TIME_WIDTH + PRIO_W;
  localparam int unsigned PAD_W  = M_TDATA_W - ID_W - 2 * RES_W - 2 * SUM_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PICK,
    ST_CALC,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // set bookkeeping
  logic [CNT_W-1:0]    cnt_q, cnt_d;        // jobs stored
  logic [CNT_W-1:0]    res_cnt_q, res_cnt_d; // results handed over
  logic                ovf_q, ovf_d;
  logic [MAX_JOBS-1:0] done_q, done_d;

  // scan read pointer and read pipeline
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  // schedule arithmetic
  logic [CT_W-1:0]       ct_q, ct_d;
  logic [CT_W-1:0]       wt_q, wt_d;
  logic [CT_W-1:0]       ta_q, ta_d;
  logic [CT_W-1:0]       base;
  logic [TIME_WIDTH-1:0] burst_q, burst_d;
  logic [IDX_W-1:0]      pick_q, pick_d;
  logic [SUM_W-1:0]      tsum_q, tsum_d, wsum_q, wsum_d;

  // result register
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic                 m_user_q, m_user_d;
  logic                 m_last_q, m_last_d;

  // store and compare unit hookup
  logic              in_beat, last_res;
  logic              mem_we, mem_re;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  scan_ctrl_t        scan_ctrl;
  logic                  pick_arrived;
  logic [IDX_W-1:0]      pick_idx;
  logic [TIME_WIDTH-1:0] pick_arr, pick_burst;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // low TIME_WIDTH bits of the time fields are kept
  assign mem_wdata = {s_axis_tdata_i[S_PRIO_LSB +: PRIO_W],
                      TIME_WIDTH'(s_axis_tdata_i[S_BURST_LSB +: IN_TIME_W]),
                      TIME_WIDTH'(s_axis_tdata_i[S_ARR_LSB +: IN_TIME_W])};

  nps_job_mem #(
    .DEPTH  (MAX_JOBS),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  nps_select #(
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IDX_W),
    .CT_W       (CT_W),
    .WORD_W     (WORD_W)
  ) u_select (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (scan_ctrl),
    .rd_idx_i       (rd_idx_q),
    .rd_word_i      (mem_rdata),
    .rd_done_i      (done_q[rd_idx_q]),
    .cur_time_i     (ct_q),
    .pick_arrived_o (pick_arrived),
    .pick_idx_o     (pick_idx),
    .pick_arr_o     (pick_arr),
    .pick_burst_o   (pick_burst)
  );

  // start time of the picked job: now, or its arrival after an idle gap
  assign base     = pick_arrived ? ct_q : CT_W'(pick_arr);
  assign last_res = ((res_cnt_q + CNT_W'(1)) == cnt_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_cnt_d = res_cnt_q;
    ovf_d     = ovf_q;
    done_d    = done_q;
    rd_ptr_d  = rd_ptr_q;
    ct_d      = ct_q;
    wt_d      = wt_q;
    ta_d      = ta_q;
    burst_d   = burst_q;
    pick_d    = pick_q;
    tsum_d    = tsum_q;
    wsum_d    = wsum_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    scan_ctrl.clear  = 1'b0;
    scan_ctrl.sample = rd_vld_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (cnt_q < CNT_W'(MAX_JOBS)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d         = ST_SCAN;
            scan_ctrl.clear = 1'b1;
            rd_ptr_d        = '0;
          end
        end
      end

      ST_SCAN: begin
        if (rd_ptr_q < cnt_q) begin
          mem_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_PICK;
        end
      end

      ST_PICK: begin
        done_d[pick_idx] = 1'b1;
        pick_d  = pick_idx;
        burst_d = pick_burst;
        ct_d    = base + CT_W'(pick_burst);
        wt_d    = base - CT_W'(pick_arr);
        state_d = ST_CALC;
      end

      ST_CALC: begin
        ta_d    = wt_q + CT_W'(burst_q);
        wsum_d  = wsum_q + SUM_W'(wt_q);
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          tsum_d    = tsum_q + SUM_W'(ta_q);
          m_valid_d = 1'b1;
          m_data_d  = {{PAD_W{1'b0}}, wsum_q, tsum_d, RES_W'(wt_q), RES_W'(ta_q),
                       ID_W'(CNT_W'(pick_q) + CNT_W'(1))};
          m_user_d  = ovf_q;
          m_last_d  = last_res;
          if (last_res) begin
            // set finished: back to an empty store
            state_d   = ST_LOAD;
            cnt_d     = '0;
            res_cnt_d = '0;
            ovf_d     = 1'b0;
            done_d    = '0;
            ct_d      = '0;
            tsum_d    = '0;
            wsum_d    = '0;
          end else begin
            state_d         = ST_SCAN;
            scan_ctrl.clear = 1'b1;
            rd_ptr_d        = '0;
            res_cnt_d       = res_cnt_q + CNT_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      res_cnt_q <= '0;
      ovf_q     <= 1'b0;
      done_q    <= '0;
      rd_ptr_q  <= '0;
      rd_vld_q  <= 1'b0;
      ct_q      <= '0;
      tsum_q    <= '0;
      wsum_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_cnt_q <= res_cnt_d;
      ovf_q     <= ovf_d;
      done_q    <= done_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_vld_q  <= mem_re;
      ct_q      <= ct_d;
      tsum_q    <= tsum_d;
      wsum_q    <= wsum_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
      m_last_q  <= m_last_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_ptr_q[IDX_W-1:0];
    wt_q     <= wt_d;
    ta_q     <= ta_d;
    burst_q  <= burst_d;
    pick_q   <= pick_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // ---- checks ----
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_JOBS))
    else $error("job count beyond capacity");

  a_res_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (res_cnt_q < cnt_q))
    else $error("more results than stored jobs");

  a_pick_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |-> !done_q[pick_idx])
    else $error("picked a job that already ran");

endmodule
